>>> sv/drc_pkg.sv
package drc_pkg;

  localparam int BpEntriesDef = 16;
  localparam int FifoDepth    = 2;
  localparam int FifoPtrW     = $clog2(FifoDepth);

  typedef enum logic [3:0] {
    OP_SET     = 4'd0,
    OP_CLEAR   = 4'd1,
    OP_READ    = 4'd2,
    OP_PROBE   = 4'd3,
    OP_TICK    = 4'd4,
    OP_SUSPEND = 4'd5,
    OP_RESUME  = 4'd6,
    OP_STEP    = 4'd7,
    OP_STATUS  = 4'd8,
    OP_EXIT    = 4'd9
  } opcode_e;

  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_USER   = 3'd1,
    RSN_STEP   = 3'd2,
    RSN_BREAK  = 3'd3,
    RSN_EXITED = 3'd4
  } reason_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOK,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] pc_value;
    logic [4:0]  entry_id;
    logic [63:0] step_count;
    logic        engine_alive;
    logic [63:0] engine_time;
  } in_item_t;

  typedef struct packed {
    logic        done_ok;
    logic [4:0]  result_id;
    logic [63:0] entry_pc;
    logic        probe_hit;
    logic        is_stopped;
    logic [2:0]  reason_code;
    logic [63:0] tick_value;
  } out_item_t;

  // classified command as it sits in the queue
  typedef struct packed {
    opcode_e     op;
    logic [63:0] pc;
    logic [4:0]  entry_id;
    logic        id_ok;
    logic        pc_nz;
    logic [63:0] budget;
    logic        alive;
    logic [63:0] now;
  } cmd_t;

endpackage

>>> sv/debug_run_control_with_breakpoints.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_stall_o | drc_pkg::in_item_t
// output  | out       | out_valid_o / out_stall_i | drc_pkg::out_item_t
//
// From the queue head: a table walk (set or probe, nonzero pc) steps through ST_WALK,
// paced by the single read port of the breakpoint memory; read entry passes ST_LOOK; all others go to ST_FIN.
// A two-entry queue lets the next items transfer in while the back end works.
// Reset clears occupancy bits at once, so no clearing pass is needed.
// A held result only stalls the back end at its final step; input stalls when the queue fills.
module debug_run_control_with_breakpoints #(
  parameter int BP_ENTRIES = drc_pkg::BpEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drc_pkg::out_item_t out_data_o
);
  import drc_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_wdata, q_rdata;

  drc_front #(
    .BP_ENTRIES(BP_ENTRIES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  drc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  drc_back #(
    .BP_ENTRIES(BP_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_rdata),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_push_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an entry without a pop");

  a_id_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_id != 5'd0) |-> out_data_o.done_ok)
    else $error("nonzero id on a failed operation");

  a_hit_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.probe_hit) |-> out_data_o.done_ok)
    else $error("probe hit without done");
`endif

endmodule

>>> sv/drc_front.sv
module drc_front #(
  parameter int BP_ENTRIES = drc_pkg::BpEntriesDef
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drc_pkg::in_item_t  in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output drc_pkg::cmd_t      q_data_o
);
  import drc_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.op       = opcode_e'(in_data_i.opcode);
    q_data_o.pc       = in_data_i.pc_value;
    q_data_o.entry_id = in_data_i.entry_id;
    q_data_o.id_ok    = (in_data_i.entry_id != 5'd0) &&
                        (32'(in_data_i.entry_id) <= 32'(BP_ENTRIES));
    q_data_o.pc_nz    = (in_data_i.pc_value != 64'd0);
    // a step of zero ticks runs one
    q_data_o.budget   = (in_data_i.step_count == 64'd0) ? 64'd1 : in_data_i.step_count;
    q_data_o.alive    = in_data_i.engine_alive;
    q_data_o.now      = in_data_i.engine_time;
  end

endmodule

>>> sv/drc_fifo.sv
module drc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  drc_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output drc_pkg::cmd_t data_o
);
  import drc_pkg::*;

  cmd_t                store_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (FifoPtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FifoPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> sv/drc_back.sv
module drc_back #(
  parameter int BP_ENTRIES = drc_pkg::BpEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  drc_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drc_pkg::out_item_t out_data_o
);
  import drc_pkg::*;

  localparam int IdxW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int CntW = $clog2(BP_ENTRIES + 1);
  localparam int IdW  = IdxW + 5;

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;

  // table walk
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] found_idx_q, found_idx_d;
  logic            empty_q, empty_d;
  logic [IdxW-1:0] empty_idx_q, empty_idx_d;

  // table storage: data in memory, occupancy in flops
  logic [63:0]           mem [BP_ENTRIES];
  logic [BP_ENTRIES-1:0] vld_q, vld_d;
  logic [IdxW-1:0]       rd_addr;
  logic [63:0]           rd_data_q;
  logic                  rd_vld_q;
  logic                  we;
  logic [IdxW-1:0]       waddr;

  // run control
  logic        hit_q, hit_d;
  logic        pause_q, pause_d;
  logic        exited_q, exited_d;
  logic        exitreq_q, exitreq_d;
  logic [63:0] budget_q, budget_d;
  reason_e     stop_q, stop_d;
  logic [63:0] last_q, last_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [IdW-1:0]  id_m1;
  logic [IdxW-1:0] cur_idx;
  logic            out_free;

  assign id_m1    = IdW'(cur_q.entry_id) - IdW'(1);
  assign cur_idx  = id_m1[IdxW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    vld_d       = vld_q;
    rd_addr     = cur_idx;
    we          = 1'b0;
    waddr       = empty_idx_q;
    hit_d       = hit_q;
    pause_d     = pause_q;
    exited_d    = exited_q;
    exitreq_d   = exitreq_q;
    budget_d    = budget_q;
    stop_d      = stop_q;
    last_d      = last_q;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          cnt_d     = '0;
          found_d   = 1'b0;
          empty_d   = 1'b0;
          if ((cmd_i.op == OP_SET || cmd_i.op == OP_PROBE) && cmd_i.pc_nz) begin
            state_d = ST_WALK;
          end else if (cmd_i.op == OP_READ && cmd_i.id_ok) begin
            state_d = ST_LOOK;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_WALK: begin
        // read issued, then compared in the next cycle
        if (cnt_q != CntW'(BP_ENTRIES)) begin
          rd_addr   = cnt_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IdxW-1:0];
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          state_d = ST_FIN;
        end
        if (cmp_vld_q) begin
          if (rd_vld_q && rd_data_q == cur_q.pc && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = cmp_idx_q;
          end
          if (!rd_vld_q && !empty_q) begin
            empty_d     = 1'b1;
            empty_idx_d = cmp_idx_q;
          end
        end
      end
      ST_LOOK: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d           = ST_IDLE;
          out_valid_d       = 1'b1;
          out_d.done_ok     = 1'b0;
          out_d.result_id   = 5'd0;
          out_d.entry_pc    = 64'd0;
          out_d.probe_hit   = 1'b0;
          unique case (cur_q.op)
            OP_SET: begin
              if (cur_q.pc_nz) begin
                if (found_q) begin
                  out_d.done_ok   = 1'b1;
                  out_d.result_id = 5'(32'(found_idx_q) + 32'd1);
                end else if (empty_q) begin
                  we                  = 1'b1;
                  vld_d[empty_idx_q]  = 1'b1;
                  out_d.done_ok       = 1'b1;
                  out_d.result_id     = 5'(32'(empty_idx_q) + 32'd1);
                end
              end
            end
            OP_CLEAR: begin
              if (cur_q.id_ok && vld_q[cur_idx]) begin
                vld_d[cur_idx] = 1'b0;
                out_d.done_ok  = 1'b1;
              end
            end
            OP_READ: begin
              if (cur_q.id_ok) begin
                out_d.done_ok  = 1'b1;
                out_d.entry_pc = rd_vld_q ? rd_data_q : 64'd0;
              end
            end
            OP_PROBE: begin
              out_d.done_ok = 1'b1;
              if (cur_q.pc_nz && found_q) begin
                out_d.probe_hit = 1'b1;
                hit_d           = 1'b1;
              end
            end
            OP_TICK: begin
              if (!exitreq_q && !exited_q && (!pause_q || budget_q != 64'd0)) begin
                out_d.done_ok = 1'b1;
                last_d        = cur_q.now;
                if (budget_q != 64'd0) begin
                  budget_d = budget_q - 64'd1;
                  if (budget_q == 64'd1) begin
                    pause_d = 1'b1;
                    if (stop_q != RSN_BREAK) begin
                      stop_d = RSN_STEP;
                    end
                  end
                end
                if (!cur_q.alive) begin
                  exited_d = 1'b1;
                  pause_d  = 1'b1;
                  budget_d = 64'd0;
                  stop_d   = RSN_EXITED;
                end else if (hit_q) begin
                  pause_d  = 1'b1;
                  budget_d = 64'd0;
                  stop_d   = RSN_BREAK;
                end
                hit_d = 1'b0;
              end
            end
            OP_SUSPEND: begin
              if (!exited_q) begin
                pause_d = 1'b1;
                if (stop_q == RSN_NONE) begin
                  stop_d = RSN_USER;
                end
                out_d.done_ok = 1'b1;
              end
            end
            OP_RESUME: begin
              if (!exited_q) begin
                pause_d       = 1'b0;
                budget_d      = 64'd0;
                stop_d        = RSN_NONE;
                out_d.done_ok = 1'b1;
              end
            end
            OP_STEP: begin
              if (!exited_q) begin
                budget_d      = cur_q.budget;
                pause_d       = 1'b1;
                stop_d        = RSN_STEP;
                out_d.done_ok = 1'b1;
              end
            end
            OP_STATUS: begin
              out_d.done_ok = 1'b1;
            end
            OP_EXIT: begin
              exitreq_d     = 1'b1;
              out_d.done_ok = 1'b1;
            end
            default: ;
          endcase
          out_d.is_stopped  = exited_d || (pause_d && budget_d == 64'd0);
          out_d.reason_code = stop_d;
          out_d.tick_value  = last_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      vld_q       <= '0;
      hit_q       <= 1'b0;
      pause_q     <= 1'b0;
      exited_q    <= 1'b0;
      exitreq_q   <= 1'b0;
      budget_q    <= 64'd0;
      stop_q      <= RSN_NONE;
      last_q      <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      empty_q     <= empty_d;
      vld_q       <= vld_d;
      hit_q       <= hit_d;
      pause_q     <= pause_d;
      exited_q    <= exited_d;
      exitreq_q   <= exitreq_d;
      budget_q    <= budget_d;
      stop_q      <= stop_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    cmp_idx_q   <= cmp_idx_d;
    found_idx_q <= found_idx_d;
    empty_idx_q <= empty_idx_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cur_q.pc;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import drc_pkg::*;

  localparam int BP_ENTRIES     = BpEntriesDef;
  localparam int POOL_SIZE      = 24;
  localparam int MID_ITEMS      = 1560;
  localparam int TOTAL_ITEMS    = 1700;
  localparam int QUIET_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  debug_run_control_with_breakpoints #(
    .BP_ENTRIES(BP_ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_item_t    run_cmds[$];
  out_item_t   expected_status[$];
  logic [63:0] pc_pool[POOL_SIZE];
  int          error_count  = 0;
  int          quiet_cycles = 0;
  bit          quiet_tail   = 1'b0;
  int          in_gap       = 0;
  int          in_calm      = 0;
  int          out_gap      = 0;
  int          out_calm     = 0;

  // shadow of the controller
  logic [63:0] bp_addr[BP_ENTRIES];
  logic        hit_pending;
  logic        halted;
  logic        has_exited;
  logic        exit_requested;
  logic [63:0] step_left;
  reason_e     halt_cause;
  logic [63:0] last_tick_time;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic out_item_t predict_run_control(in_item_t item);
    out_item_t res;
    logic      id_ok;
    int        slot;
    res   = '0;
    id_ok = (item.entry_id != 0) && (item.entry_id <= BP_ENTRIES);
    case (item.opcode)
      OP_SET: begin
        if (item.pc_value != '0) begin
          for (slot = 0; slot < BP_ENTRIES; slot++)
            if (res.result_id == 0 && bp_addr[slot] == item.pc_value)
              res.result_id = 5'(slot + 1);
          for (slot = 0; slot < BP_ENTRIES; slot++)
            if (res.result_id == 0 && bp_addr[slot] == '0) begin
              bp_addr[slot] = item.pc_value;
              res.result_id = 5'(slot + 1);
            end
        end
        res.done_ok = (res.result_id != 0);
      end
      OP_CLEAR: begin
        if (id_ok && bp_addr[item.entry_id - 1] != '0) begin
          bp_addr[item.entry_id - 1] = '0;
          res.done_ok = 1'b1;
        end
      end
      OP_READ: begin
        if (id_ok) begin
          res.entry_pc = bp_addr[item.entry_id - 1];
          res.done_ok  = 1'b1;
        end
      end
      OP_PROBE: begin
        if (item.pc_value != '0)
          for (slot = 0; slot < BP_ENTRIES; slot++)
            if (bp_addr[slot] == item.pc_value) res.probe_hit = 1'b1;
        if (res.probe_hit) hit_pending = 1'b1;
        res.done_ok = 1'b1;
      end
      OP_TICK: begin
        if (!exit_requested && !has_exited && (!halted || step_left != 0)) begin
          last_tick_time = item.engine_time;
          if (step_left != 0) begin
            step_left = step_left - 64'd1;
            if (step_left == 0) begin
              halted = 1'b1;
              if (halt_cause != RSN_BREAK) halt_cause = RSN_STEP;
            end
          end
          if (!item.engine_alive) begin
            has_exited = 1'b1;
            halted     = 1'b1;
            step_left  = '0;
            halt_cause = RSN_EXITED;
          end else if (hit_pending) begin
            halted     = 1'b1;
            step_left  = '0;
            halt_cause = RSN_BREAK;
          end
          hit_pending = 1'b0;
          res.done_ok = 1'b1;
        end
      end
      OP_SUSPEND: begin
        if (!has_exited) begin
          halted = 1'b1;
          if (halt_cause == RSN_NONE) halt_cause = RSN_USER;
          res.done_ok = 1'b1;
        end
      end
      OP_RESUME: begin
        if (!has_exited) begin
          halted      = 1'b0;
          step_left   = '0;
          halt_cause  = RSN_NONE;
          res.done_ok = 1'b1;
        end
      end
      OP_STEP: begin
        if (!has_exited) begin
          step_left   = (item.step_count == '0) ? 64'd1 : item.step_count;
          halted      = 1'b1;
          halt_cause  = RSN_STEP;
          res.done_ok = 1'b1;
        end
      end
      OP_STATUS: res.done_ok = 1'b1;
      OP_EXIT: begin
        exit_requested = 1'b1;
        res.done_ok    = 1'b1;
      end
      default: ;
    endcase
    res.is_stopped  = has_exited || (halted && step_left == 0);
    res.reason_code = halt_cause;
    res.tick_value  = last_tick_time;
    return res;
  endfunction

  task automatic push_cmd(logic [3:0] op, logic [63:0] pc, logic [4:0] id,
                          logic [63:0] count, logic alive, logic [63:0] now);
    in_item_t item;
    item.opcode       = op;
    item.pc_value     = pc;
    item.entry_id     = id;
    item.step_count   = count;
    item.engine_alive = alive;
    item.engine_time  = now;
    run_cmds.insert(run_cmds.size(), item);
  endtask

  // allow_exit lets ticks end the machine and lets exit requests through
  task automatic add_random_cmd(bit allow_exit);
    int          roll;
    logic [3:0]  op;
    logic [63:0] pc;
    logic [4:0]  id;
    logic [63:0] count;
    logic        alive;
    roll = $urandom_range(0, 99);
    if (roll < 20)      op = OP_SET;
    else if (roll < 30) op = OP_CLEAR;
    else if (roll < 38) op = OP_READ;
    else if (roll < 52) op = OP_PROBE;
    else if (roll < 80) op = OP_TICK;
    else if (roll < 84) op = OP_SUSPEND;
    else if (roll < 89) op = OP_RESUME;
    else if (roll < 95) op = OP_STEP;
    else if (roll < 97) op = OP_STATUS;
    else if (roll < 99) op = 4'($urandom_range(10, 15));
    else                op = allow_exit ? OP_EXIT : OP_STATUS;
    pc = ($urandom_range(0, 9) == 0) ? rand64() : pc_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 29) == 0) pc = '0;
    id = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
    count = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 6));
    alive = ($urandom_range(0, 15) != 0);
    if (op == OP_TICK && !allow_exit) alive = 1'b1;
    push_cmd(op, pc, id, count, alive, rand64());
  endtask

  // driver
  always @(posedge clk_i) begin
    logic holding;
    int   roll;
    if (rst_ni) begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_status.insert(expected_status.size(), predict_run_control(in_data_i));
        run_cmds.delete(0);
        holding = 1'b0;
      end
      quiet_tail <= (run_cmds.size() <= QUIET_ITEMS);
      if (!holding) begin
        if (in_gap == 0 && !quiet_tail) begin
          roll = $urandom_range(0, 99);
          if (in_calm > 0) in_calm--;
          else if (roll < 10) in_gap = $urandom_range(1, 19);
          else if (roll < 13) in_calm = $urandom_range(20, 80);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (run_cmds.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= run_cmds[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    int        roll;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $error("unexpected result transfer: %h", out_data_o);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("done_ok", want.done_ok, out_data_o.done_ok);
          check_field("result_id", want.result_id, out_data_o.result_id);
          check_field("entry_pc", want.entry_pc, out_data_o.entry_pc);
          check_field("probe_hit", want.probe_hit, out_data_o.probe_hit);
          check_field("is_stopped", want.is_stopped, out_data_o.is_stopped);
          check_field("reason_code", want.reason_code, out_data_o.reason_code);
          check_field("tick_value", want.tick_value, out_data_o.tick_value);
        end
      end
      if (quiet_tail) begin
        out_stall_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (out_calm > 0) begin
          out_calm--;
          out_stall_i <= 1'b0;
        end else if (roll < 12) begin
          out_gap = $urandom_range(1, 19) - 1;
          out_stall_i <= 1'b1;
        end else begin
          if (roll < 15) out_calm = $urandom_range(20, 80);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) quiet_cycles <= 0;
    else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int roll;
    int k;
    int j;
    for (j = 0; j < BP_ENTRIES; j++) bp_addr[j] = '0;
    hit_pending    = 1'b0;
    halted         = 1'b0;
    has_exited     = 1'b0;
    exit_requested = 1'b0;
    step_left      = '0;
    halt_cause     = RSN_NONE;
    last_tick_time = '0;

    pc_pool[0] = '1;
    pc_pool[1] = 64'd1;
    pc_pool[2] = 64'h8000_0000_0000_0000;
    for (j = 3; j < POOL_SIZE; j++) begin
      pc_pool[j] = rand64();
      if (pc_pool[j] == '0) pc_pool[j] = 64'(j);
    end

    // opening: table edges, bad ids, latch, step and suspend behaviour
    push_cmd(OP_STATUS, '0, '0, '0, 1'b1, '0);
    push_cmd(OP_SET, '0, 5'd1, '0, 1'b1, rand64());
    push_cmd(OP_SET, '1, 5'd1, '0, 1'b1, rand64());
    push_cmd(OP_SET, '1, 5'd2, '0, 1'b1, rand64());
    push_cmd(OP_SET, 64'd1, 5'd3, '0, 1'b1, rand64());
    push_cmd(OP_READ, '0, 5'd0, '0, 1'b1, rand64());
    push_cmd(OP_READ, '0, 5'd31, '1, 1'b1, rand64());
    push_cmd(OP_READ, '0, 5'd17, '0, 1'b1, rand64());
    push_cmd(OP_READ, '0, 5'd1, '0, 1'b1, rand64());
    push_cmd(OP_READ, '0, 5'd9, '0, 1'b1, rand64());
    push_cmd(OP_CLEAR, '0, 5'd0, '0, 1'b1, rand64());
    push_cmd(OP_CLEAR, '0, 5'd20, '0, 1'b1, rand64());
    push_cmd(OP_CLEAR, '0, 5'd9, '0, 1'b1, rand64());
    push_cmd(OP_PROBE, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_PROBE, 64'h8000_0000_0000_0000, '0, '0, 1'b1, rand64());
    push_cmd(OP_PROBE, '1, '0, '0, 1'b1, rand64());
    // latch survives the entry being cleared
    push_cmd(OP_CLEAR, '0, 5'd1, '0, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, '1);
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_RESUME, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_SUSPEND, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_STEP, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, '0);
    push_cmd(OP_STEP, '0, '0, '1, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, rand64());
    push_cmd(4'd10, '1, 5'd31, '1, 1'b0, '1);
    push_cmd(4'd15, '0, '0, '0, 1'b1, '0);
    push_cmd(OP_RESUME, '0, '0, '0, 1'b1, rand64());

    // middle: no exit, so run control stays reachable
    while (run_cmds.size() < MID_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        // push the table to full and beyond
        for (j = 0; j < BP_ENTRIES + 2; j++)
          push_cmd(OP_SET, rand64() | 64'd1, '0, '0, 1'b1, rand64());
        push_cmd(OP_READ, '0, 5'(BP_ENTRIES), '0, 1'b1, rand64());
      end else if (roll < 7) begin
        k = $urandom_range(1, 4);
        push_cmd(OP_STEP, '0, '0, 64'(k), 1'b1, rand64());
        for (j = 0; j <= k; j++) begin
          if ($urandom_range(0, 3) == 0)
            push_cmd(OP_PROBE, pc_pool[$urandom_range(0, POOL_SIZE - 1)], '0, '0, 1'b1,
                     rand64());
          push_cmd(OP_TICK, '0, '0, '0, 1'b1, rand64());
        end
      end else begin
        add_random_cmd(1'b0);
      end
    end

    // closing: breakpoint stop, then the machine exits for good
    push_cmd(OP_RESUME, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_SET, pc_pool[5], '0, '0, 1'b1, rand64());
    push_cmd(OP_PROBE, pc_pool[5], '0, '0, 1'b1, rand64());
    push_cmd(OP_STEP, '0, '0, 64'd2, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_RESUME, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b0, rand64());
    push_cmd(OP_SUSPEND, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_RESUME, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_STEP, '0, '0, 64'd3, 1'b1, rand64());
    push_cmd(OP_TICK, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_EXIT, '0, '0, '0, 1'b1, rand64());
    push_cmd(OP_STATUS, '0, '0, '0, 1'b1, rand64());
    while (run_cmds.size() < TOTAL_ITEMS) add_random_cmd(1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (run_cmds.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
